// ===== sv/gimbal_two_axis_pid_controller_core_defines.svh =====
// Assertion macros for the gimbal controller core
`ifndef GIMBAL_TWO_AXIS_PID_CONTROLLER_CORE_DEFINES_SVH
`define GIMBAL_TWO_AXIS_PID_CONTROLLER_CORE_DEFINES_SVH

// Clocked property, off during reset
`define GTPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition followed by a consequence in the next cycle
`define GTPC_NEXT(lbl, cond, cons, msg) \
  `GTPC_ASSERT(lbl, (cond) |=> (cons), msg)

`endif

// ===== sv/gtpc_pkg.sv =====
// Shared constants and codes for the gimbal controller core
package gtpc_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int DRIVE_LIMIT = 29999;
  localparam int INTEG_LIMIT = 19999;
  localparam int ERROR_LIMIT = 9999;
  localparam int P_CLAMP     = 400;

  // Field widths
  localparam int W_COORD = 10;
  localparam int W_LOSS  = 8;
  localparam int W_GYRO  = 16;
  localparam int W_STICK = 11;
  localparam int W_POS   = 13;
  localparam int W_SPIN  = 12;
  localparam int W_DRIVE = 16;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_CENTER_X  = 3'd0;
  localparam logic [2:0] REG_CENTER_Y  = 3'd1;
  localparam logic [2:0] REG_YAW_OFS   = 3'd2;
  localparam logic [2:0] REG_SWEEP_TST = 3'd3;
  localparam logic [2:0] REG_SWEEP_LO  = 3'd4;
  localparam logic [2:0] REG_SWEEP_HI  = 3'd5;
  localparam logic [2:0] REG_SWEEP_STP = 3'd6;

  // Control path of one tick
  localparam logic [1:0] PATH_TRACK  = 2'd0;
  localparam logic [1:0] PATH_SEARCH = 2'd1;
  localparam logic [1:0] PATH_MANUAL = 2'd2;
  localparam logic [1:0] PATH_OFF    = 2'd3;

  // Sweep direction
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

endpackage

// ===== sv/gtpc_in_if.sv =====
// Input item channel: one control tick
interface gtpc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic [1:0]                            switch_pos;
  logic [gtpc_pkg::W_LOSS-1:0]           loss_count;
  logic [gtpc_pkg::W_COORD-1:0]          target_x;
  logic [gtpc_pkg::W_COORD-1:0]          target_y;
  logic [gtpc_pkg::W_COORD-1:0]          target_width;
  logic signed [gtpc_pkg::W_GYRO-1:0]    gyro_yaw;
  logic signed [gtpc_pkg::W_GYRO-1:0]    gyro_pitch;
  logic [gtpc_pkg::W_STICK-1:0]          stick_yaw;
  logic [gtpc_pkg::W_STICK-1:0]          stick_pitch;
  logic [gtpc_pkg::W_POS-1:0]            pitch_position;
  logic signed [gtpc_pkg::W_SPIN-1:0]    spin_rate;

  modport source (output valid, mode, switch_pos, loss_count, target_x, target_y,
                  target_width, gyro_yaw, gyro_pitch, stick_yaw, stick_pitch,
                  pitch_position, spin_rate, input ready);
  modport sink (input valid, mode, switch_pos, loss_count, target_x, target_y,
                target_width, gyro_yaw, gyro_pitch, stick_yaw, stick_pitch,
                pitch_position, spin_rate, output ready);
endinterface

// ===== sv/gtpc_out_if.sv =====
// Result item channel: motor drive commands
interface gtpc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gtpc_pkg::W_DRIVE-1:0] yaw_drive;
  logic signed [gtpc_pkg::W_DRIVE-1:0] pitch_drive;
  logic                                drive_enabled;

  modport source (output valid, yaw_drive, pitch_drive, drive_enabled, input ready);
  modport sink (input valid, yaw_drive, pitch_drive, drive_enabled, output ready);
endinterface

// ===== sv/gtpc_smul.sv =====
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle
module gtpc_smul #(
  parameter int XW = gtpc_pkg::FRAC_BITS_DEF + 18,
  parameter int MW = gtpc_pkg::FRAC_BITS_DEF + 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [XW-1:0]    x,
  input  logic [MW-1:0]           m,
  output logic                    done,
  output logic signed [XW+MW-1:0] p
);
  localparam int PW = XW + MW;
  localparam int CW = $clog2(MW + 1);

  logic signed [PW-1:0] acc_r;
  logic signed [PW-1:0] xs_r;
  logic [MW-1:0]        m_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (!busy_r && start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Shift-add: add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      acc_r <= '0;
      xs_r  <= PW'(x);
      m_r   <= m;
    end else if (busy_r) begin
      if (m_r[0]) begin
        acc_r <= acc_r + xs_r;
      end
      xs_r <= xs_r <<< 1;
      m_r  <= m_r >> 1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

// ===== sv/gimbal_two_axis_pid_controller_core.sv =====
// Flow: a disabled tick's item goes from accept straight to ST_OUT; any other tick runs
// up to twelve products through one bit-serial multiplier; without a target the aim products are skipped.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (synchronous, rst_n low): registers to defaults, loop state cleared,
// sweep target 400, output channel empty.
`include "gimbal_two_axis_pid_controller_core_defines.svh"
module gimbal_two_axis_pid_controller_core #(
  parameter int FRAC_BITS = gtpc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gtpc_in_if.sink                     in_if,
  gtpc_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtpc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  localparam int EW = FRAC_BITS + 18;
  localparam int XW = EW;
  localparam int MW = FRAC_BITS + 3;
  localparam int PW = XW + MW;
  localparam int RW = FRAC_BITS + 16;
  localparam int IW = FRAC_BITS + 16;

  localparam logic [MW-1:0] QC_095 = MW'(((longint'(95) << FRAC_BITS) + 50) / 100);
  localparam logic [MW-1:0] QC_06  = MW'(((longint'(6) << FRAC_BITS) + 5) / 10);
  localparam logic [MW-1:0] QC_072 = MW'(((longint'(72) << FRAC_BITS) + 50) / 100);
  localparam logic [MW-1:0] QC_09  = MW'(((longint'(9) << FRAC_BITS) + 5) / 10);
  localparam logic [MW-1:0] QC_188 = MW'(((longint'(188) << FRAC_BITS) + 50) / 100);
  localparam logic [MW-1:0] QC_118 = MW'(((longint'(118) << FRAC_BITS) + 50) / 100);
  localparam logic [MW-1:0] QC_012 = MW'(((longint'(12) << FRAC_BITS) + 50) / 100);
  localparam logic [MW-1:0] QC_032 = MW'(((longint'(32) << FRAC_BITS) + 50) / 100);
  localparam logic [MW-1:0] QC_25  = MW'(((longint'(25) << FRAC_BITS) + 5) / 10);
  localparam logic [MW-1:0] QC_15  = MW'(((longint'(15) << FRAC_BITS) + 5) / 10);
  localparam logic [MW-1:0] QC_12  = MW'(((longint'(12) << FRAC_BITS) + 5) / 10);
  localparam logic [MW-1:0] QC_02  = MW'(((longint'(2) << FRAC_BITS) + 5) / 10);
  localparam logic [MW-1:0] G_ONE  = MW'(longint'(1) << FRAC_BITS);
  localparam logic [MW-1:0] G_TWO  = MW'(longint'(2) << FRAC_BITS);
  localparam logic [MW-1:0] G_16   = MW'(16);
  localparam logic [MW-1:0] G_17   = MW'(17);
  localparam logic [MW-1:0] G_18   = MW'(18);

  localparam logic signed [EW-1:0] C_YAW =
    EW'(((longint'(76207) << FRAC_BITS) + 5000) / 10000);
  localparam logic signed [EW-1:0] C_PIT =
    EW'(((longint'(3321) << FRAC_BITS) + 500) / 1000);
  localparam logic signed [EW-1:0] ELIM_Q =
    EW'(longint'(gtpc_pkg::ERROR_LIMIT) << FRAC_BITS);
  localparam logic signed [PW-1:0] ILIM_Q =
    PW'(longint'(gtpc_pkg::INTEG_LIMIT) << FRAC_BITS);
  localparam logic signed [PW-1:0] DLIM_Q =
    PW'(longint'(gtpc_pkg::DRIVE_LIMIT) << FRAC_BITS);
  localparam logic signed [PW-1:0] PCLAMP = PW'(gtpc_pkg::P_CLAMP);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_TGT  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [3:0] K_EX = 4'd0;
  localparam logic [3:0] K_DX = 4'd1;
  localparam logic [3:0] K_EY = 4'd2;
  localparam logic [3:0] K_DY = 4'd3;
  localparam logic [3:0] K_YI = 4'd4;
  localparam logic [3:0] K_YP = 4'd5;
  localparam logic [3:0] K_YD = 4'd6;
  localparam logic [3:0] K_YO = 4'd7;
  localparam logic [3:0] K_PI = 4'd8;
  localparam logic [3:0] K_PP = 4'd9;
  localparam logic [3:0] K_PD = 4'd10;
  localparam logic [3:0] K_PO = 4'd11;

  function automatic logic signed [PW-1:0] trunc_q(input logic signed [PW-1:0] v);
    if (v < 0) begin
      trunc_q = -((-v) >>> FRAC_BITS);
    end else begin
      trunc_q = v >>> FRAC_BITS;
    end
  endfunction

  // Configuration registers
  logic [9:0]  cx_r, cy_r;
  logic [7:0]  off_r;
  logic        swt_r;
  logic [12:0] swlo_r, swhi_r;
  logic [11:0] swstep_r;

  // Loop state
  logic                  cap_r;
  logic signed [RW-1:0]  yrt_r, prt_r;
  logic signed [IW-1:0]  yint_r, pint_r;
  logic signed [17:0]    prev_yr_r;
  logic signed [15:0]    prev_pr_r;
  logic signed [11:0]    prev_ex_r, prev_ey_r;
  logic [1:0]            sdir_r;
  logic signed [12:0]    stgt_r;

  // Sequencer
  logic [1:0] st_r;
  logic [3:0] k_r;
  logic       issued_r;
  logic [1:0] path_r;
  logic       tgt_r;
  logic       loss1_r;

  // Latched tick data and work registers
  logic signed [11:0]   ex_r, ey_r;
  logic signed [12:0]   dx_r, dy_r;
  logic signed [17:0]   yrate_r;
  logic signed [15:0]   gp_r;
  logic signed [11:0]   spin_r;
  logic [10:0]          sy_r, sp_r;
  logic signed [PW-1:0] tmp_r;
  logic signed [13:0]   ax_r, ay_r;
  logic signed [EW-1:0] yerr_r, perr_r;
  logic signed [15:0]   ydrv_r, pdrv_r;
  logic                 en_r;

  // Output register
  logic               ov_r;
  logic signed [15:0] oy_r, op_r;
  logic               oe_r;

  // Accept-side logic
  logic                 in_fire;
  logic [10:0]          aim_row;
  logic                 cap_nxt;
  logic [1:0]           path_nxt;
  logic signed [11:0]   ex_nxt, ey_nxt;
  logic                 tupd_nxt;
  logic signed [17:0]   yrate_nxt;
  logic [1:0]           sdir_nxt;
  logic signed [12:0]   stgt_nxt;

  assign in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (st_r == ST_IDLE);

  always_comb begin
    aim_row  = {1'b0, cy_r} + ((in_if.target_width <= 10'd6) ? 11'd5 : 11'd0);
    cap_nxt  = in_if.mode ? (in_if.loss_count < 8'd3) : cap_r;
    if (in_if.switch_pos == 2'd0) begin
      path_nxt = gtpc_pkg::PATH_OFF;
    end else if (in_if.mode && cap_nxt) begin
      path_nxt = gtpc_pkg::PATH_TRACK;
    end else if (in_if.mode) begin
      path_nxt = gtpc_pkg::PATH_SEARCH;
    end else begin
      path_nxt = gtpc_pkg::PATH_MANUAL;
    end
    ex_nxt   = $signed({2'b00, in_if.target_x}) - $signed({2'b00, cx_r});
    ey_nxt   = $signed({2'b00, in_if.target_y}) - $signed({1'b0, aim_row});
    tupd_nxt = (path_nxt == gtpc_pkg::PATH_TRACK) &&
               ((in_if.target_x != '0) || (in_if.target_y != '0));
    if (in_if.mode) begin
      yrate_nxt = 18'(in_if.gyro_yaw);
    end else begin
      yrate_nxt = 18'(in_if.gyro_yaw) + 18'($signed({1'b0, off_r}));
    end
    if (in_if.pitch_position >= swhi_r) begin
      sdir_nxt = gtpc_pkg::DIR_DOWN;
    end else if (in_if.pitch_position <= swlo_r) begin
      sdir_nxt = gtpc_pkg::DIR_UP;
    end else begin
      sdir_nxt = sdir_r;
    end
    if (sdir_nxt == gtpc_pkg::DIR_UP) begin
      stgt_nxt = $signed({1'b0, swstep_r});
    end else if (sdir_nxt == gtpc_pkg::DIR_DOWN) begin
      stgt_nxt = -$signed({1'b0, swstep_r});
    end else begin
      stgt_nxt = stgt_r;
    end
  end

  // Gains for the current path
  logic [MW-1:0] igy, pgy, ogy, dgy, igp, pgp, ogp, dgp;

  always_comb begin
    case (path_r)
      gtpc_pkg::PATH_TRACK: begin
        igy = QC_188; pgy = G_17; ogy = QC_012; dgy = QC_25;
        igp = QC_118; pgp = G_16; ogp = QC_032; dgp = G_TWO;
      end
      gtpc_pkg::PATH_SEARCH: begin
        igy = QC_188; pgy = G_16; ogy = G_ONE; dgy = QC_15;
        igp = QC_118; pgp = G_16; ogp = G_ONE; dgp = G_ONE;
      end
      default: begin
        igy = QC_118; pgy = G_18; ogy = G_ONE; dgy = QC_12;
        igp = QC_118; pgp = G_18; ogp = G_ONE; dgp = QC_02;
      end
    endcase
  end

  // Multiplier operands
  logic signed [XW-1:0] x_sel;
  logic [MW-1:0]        m_sel;
  logic signed [EW-1:0] ydr, pdr;
  logic                 mul_start, mul_done;
  logic signed [PW-1:0] mul_p;

  assign ydr = EW'(yrate_r) - EW'(prev_yr_r);
  assign pdr = EW'(gp_r) - EW'(prev_pr_r);

  always_comb begin
    case (k_r)
      K_EX:    begin x_sel = XW'(ex_r);   m_sel = QC_095; end
      K_DX:    begin x_sel = XW'(dx_r);   m_sel = QC_06;  end
      K_EY:    begin x_sel = XW'(ey_r);   m_sel = QC_072; end
      K_DY:    begin x_sel = XW'(dy_r);   m_sel = QC_09;  end
      K_YI:    begin x_sel = yerr_r;      m_sel = igy;    end
      K_YP:    begin x_sel = yerr_r;      m_sel = pgy;    end
      K_YD:    begin x_sel = ydr;         m_sel = dgy;    end
      K_YO:    begin x_sel = XW'(yint_r); m_sel = ogy;    end
      K_PI:    begin x_sel = perr_r;      m_sel = igp;    end
      K_PP:    begin x_sel = perr_r;      m_sel = pgp;    end
      K_PD:    begin x_sel = pdr;         m_sel = dgp;    end
      default: begin x_sel = XW'(pint_r); m_sel = ogp;    end
    endcase
  end

  assign mul_start = (st_r == ST_MUL) && !issued_r;

  gtpc_smul #(
    .XW (XW),
    .MW (MW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (x_sel),
    .m     (m_sel),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Post-processing of a finished product
  logic signed [PW-1:0] p_floor, tr_in, tr_out, p_clamp;
  logic signed [PW-1:0] isum, isum_c, o_sum, o_sat, drv_c;
  logic signed [EW-1:0] err_sel;

  always_comb begin
    p_floor = mul_p >>> FRAC_BITS;
    case (k_r)
      K_DX:    tr_in = (tmp_r <<< FRAC_BITS) + mul_p;
      K_DY:    tr_in = tmp_r + mul_p;
      default: tr_in = mul_p;
    endcase
    tr_out = trunc_q(tr_in);
    if (tr_out > PCLAMP) begin
      p_clamp = PCLAMP;
    end else if (tr_out < -PCLAMP) begin
      p_clamp = -PCLAMP;
    end else begin
      p_clamp = tr_out;
    end
    if (k_r == K_YI) begin
      isum    = PW'(yint_r) + p_floor;
      err_sel = yerr_r;
    end else begin
      isum    = PW'(pint_r) + p_floor;
      err_sel = perr_r;
    end
    if ((err_sel > ELIM_Q) || (err_sel < -ELIM_Q)) begin
      isum_c = '0;
    end else if (isum > ILIM_Q) begin
      isum_c = ILIM_Q;
    end else if (isum < -ILIM_Q) begin
      isum_c = -ILIM_Q;
    end else begin
      isum_c = isum;
    end
    o_sum = tmp_r + p_floor;
    if (o_sum > DLIM_Q) begin
      o_sat = DLIM_Q;
    end else if (o_sum < -DLIM_Q) begin
      o_sat = -DLIM_Q;
    end else begin
      o_sat = o_sum;
    end
    drv_c = trunc_q(o_sat);
  end

  // Rate targets and rate errors
  logic signed [EW-1:0] ax_e, ay_e, ax10, ay10, spin_e, spin55, dsy, dsp;
  logic signed [EW-1:0] yrt_t, prt_t, yerr_t, perr_t;

  always_comb begin
    ax_e   = EW'(ax_r);
    ay_e   = EW'(ay_r);
    ax10   = (ax_e <<< 3) + (ax_e <<< 1);
    ay10   = (ay_e <<< 3) + (ay_e <<< 1);
    spin_e = EW'(spin_r);
    spin55 = (spin_e <<< 6) - (spin_e <<< 3) - spin_e;
    dsy    = EW'($signed({1'b0, sy_r}) - 12'sd1024);
    dsp    = EW'($signed({1'b0, sp_r}) - 12'sd1024);
    case (path_r)
      gtpc_pkg::PATH_TRACK: begin
        yrt_t = tgt_r ? -(ax10 <<< FRAC_BITS) : EW'(yrt_r);
        prt_t = tgt_r ? -(ay10 <<< FRAC_BITS) : EW'(prt_r);
        if (loss1_r) begin
          yrt_t = '0;
          prt_t = '0;
        end
      end
      gtpc_pkg::PATH_SEARCH: begin
        if (!swt_r) begin
          yrt_t = (spin55 <<< (FRAC_BITS - 4)) - (EW'(8) <<< FRAC_BITS);
          prt_t = '0;
        end else begin
          yrt_t = '0;
          prt_t = EW'(stgt_r) <<< FRAC_BITS;
        end
      end
      default: begin
        yrt_t = -(dsy <<< (FRAC_BITS + 3));
        prt_t = dsp <<< (FRAC_BITS + 3);
      end
    endcase
    yerr_t = yrt_t - (EW'(yrate_r) <<< FRAC_BITS) + C_YAW;
    perr_t = prt_t - (EW'(gp_r) <<< FRAC_BITS) - C_PIT;
  end

  // Tick data capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_r    <= ex_nxt;
      ey_r    <= ey_nxt;
      dx_r    <= 13'(ex_nxt) - 13'(prev_ex_r);
      dy_r    <= 13'(ey_nxt) - 13'(prev_ey_r);
      yrate_r <= yrate_nxt;
      gp_r    <= in_if.gyro_pitch;
      spin_r  <= in_if.spin_rate;
      sy_r    <= in_if.stick_yaw;
      sp_r    <= in_if.stick_pitch;
    end
  end

  // Sequencer, loop state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= 10'd560;
      cy_r      <= 10'd440;
      off_r     <= 8'd9;
      swt_r     <= 1'b0;
      swlo_r    <= 13'd3700;
      swhi_r    <= 13'd4500;
      swstep_r  <= 12'd300;
      cap_r     <= 1'b0;
      yrt_r     <= '0;
      prt_r     <= '0;
      yint_r    <= '0;
      pint_r    <= '0;
      prev_yr_r <= '0;
      prev_pr_r <= '0;
      prev_ex_r <= '0;
      prev_ey_r <= '0;
      sdir_r    <= gtpc_pkg::DIR_NONE;
      stgt_r    <= 13'sd400;
      st_r      <= ST_IDLE;
      k_r       <= K_EX;
      issued_r  <= 1'b0;
      path_r    <= gtpc_pkg::PATH_OFF;
      tgt_r     <= 1'b0;
      loss1_r   <= 1'b0;
      tmp_r     <= '0;
      ax_r      <= '0;
      ay_r      <= '0;
      yerr_r    <= '0;
      perr_r    <= '0;
      ydrv_r    <= '0;
      pdrv_r    <= '0;
      en_r      <= 1'b0;
      ov_r      <= 1'b0;
      oy_r      <= '0;
      op_r      <= '0;
      oe_r      <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          gtpc_pkg::REG_CENTER_X:  cx_r     <= pwdata[9:0];
          gtpc_pkg::REG_CENTER_Y:  cy_r     <= pwdata[9:0];
          gtpc_pkg::REG_YAW_OFS:   off_r    <= pwdata[7:0];
          gtpc_pkg::REG_SWEEP_TST: swt_r    <= pwdata[0];
          gtpc_pkg::REG_SWEEP_LO:  swlo_r   <= pwdata[12:0];
          gtpc_pkg::REG_SWEEP_HI:  swhi_r   <= pwdata[12:0];
          gtpc_pkg::REG_SWEEP_STP: swstep_r <= pwdata[11:0];
          default: ;
        endcase
      end

      // Drop the taken item unless a new one is loaded this cycle
      if (ov_r && out_if.ready && (st_r != ST_OUT)) begin
        ov_r <= 1'b0;
      end

      case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            cap_r   <= cap_nxt;
            path_r  <= path_nxt;
            tgt_r   <= tupd_nxt;
            loss1_r <= (in_if.loss_count == 8'd1);
            if (path_nxt == gtpc_pkg::PATH_OFF) begin
              ydrv_r <= '0;
              pdrv_r <= '0;
              en_r   <= 1'b0;
              st_r   <= ST_OUT;
            end else begin
              if (tupd_nxt) begin
                prev_ex_r <= ex_nxt;
                prev_ey_r <= ey_nxt;
              end
              if (path_nxt == gtpc_pkg::PATH_SEARCH) begin
                sdir_r <= sdir_nxt;
                stgt_r <= stgt_nxt;
              end
              k_r      <= K_EX;
              issued_r <= 1'b0;
              st_r     <= tupd_nxt ? ST_MUL : ST_TGT;
            end
          end
        end
        ST_TGT: begin
          yrt_r    <= RW'(yrt_t);
          prt_r    <= RW'(prt_t);
          yerr_r   <= yerr_t;
          perr_r   <= perr_t;
          k_r      <= K_YI;
          issued_r <= 1'b0;
          st_r     <= ST_MUL;
        end
        ST_MUL: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end
          if (mul_done) begin
            issued_r <= 1'b0;
            k_r      <= k_r + 4'd1;
            case (k_r)
              K_EX: tmp_r <= p_clamp;
              K_DX: ax_r  <= tr_out[13:0];
              K_EY: tmp_r <= mul_p;
              K_DY: begin
                ay_r <= tr_out[13:0];
                st_r <= ST_TGT;
              end
              K_YI: yint_r <= isum_c[IW-1:0];
              K_YP: tmp_r  <= mul_p;
              K_YD: tmp_r  <= tmp_r - mul_p;
              K_YO: ydrv_r <= drv_c[15:0];
              K_PI: pint_r <= isum_c[IW-1:0];
              K_PP: tmp_r  <= mul_p;
              K_PD: tmp_r  <= tmp_r - mul_p;
              K_PO: begin
                pdrv_r    <= drv_c[15:0];
                en_r      <= 1'b1;
                prev_yr_r <= yrate_r;
                prev_pr_r <= gp_r;
                st_r      <= ST_OUT;
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          // Hand the result over once the output register is free
          if (!ov_r || out_if.ready) begin
            ov_r <= 1'b1;
            oy_r <= ydrv_r;
            op_r <= pdrv_r;
            oe_r <= en_r;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid         = ov_r;
  assign out_if.yaw_drive     = oy_r;
  assign out_if.pitch_drive   = op_r;
  assign out_if.drive_enabled = oe_r;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      gtpc_pkg::REG_CENTER_X:  prdata = {22'd0, cx_r};
      gtpc_pkg::REG_CENTER_Y:  prdata = {22'd0, cy_r};
      gtpc_pkg::REG_YAW_OFS:   prdata = {24'd0, off_r};
      gtpc_pkg::REG_SWEEP_TST: prdata = {31'd0, swt_r};
      gtpc_pkg::REG_SWEEP_LO:  prdata = {19'd0, swlo_r};
      gtpc_pkg::REG_SWEEP_HI:  prdata = {19'd0, swhi_r};
      gtpc_pkg::REG_SWEEP_STP: prdata = {20'd0, swstep_r};
      default:                 prdata = 32'd0;
    endcase
  end

  `GTPC_NEXT(a_one_item_in_flight, in_if.valid && in_if.ready, !in_if.ready, "item taken while busy")
  `GTPC_ASSERT(a_off_drives_zero, (out_if.valid && !out_if.drive_enabled) |-> (out_if.yaw_drive == 16'sd0 && out_if.pitch_drive == 16'sd0), "disabled item with nonzero drive")
  `GTPC_ASSERT(a_drive_range, out_if.valid |-> (out_if.yaw_drive <= 16'sd29999 && out_if.yaw_drive >= -16'sd29999 && out_if.pitch_drive <= 16'sd29999 && out_if.pitch_drive >= -16'sd29999), "drive beyond limit")
  `GTPC_ASSERT(a_integ_range, (PW'(yint_r) <= ILIM_Q) && (PW'(yint_r) >= -ILIM_Q) && (PW'(pint_r) <= ILIM_Q) && (PW'(pint_r) >= -ILIM_Q), "integral beyond clamp")
endmodule

// ===== tb/sv/tb_gimbal_two_axis_pid_controller_core_chk.sv =====
// Scoreboard for the gimbal controller core: predicts drive commands and compares them
`timescale 1ns / 100ps
module tb_gimbal_two_axis_pid_controller_core_chk (
  input  logic         clk,
  input  logic         rst_n,
  gtpc_in_if           in_if,
  gtpc_out_if          out_if,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           pending_count
);
  localparam int FB = gtpc_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct packed {
    logic signed [15:0] yaw_drive;
    logic signed [15:0] pitch_drive;
    logic               drive_enabled;
  } drive_t;

  drive_t drive_q[$];

  longint ctr_x, ctr_y, yaw_ofs, sw_test, sw_lo, sw_hi, sw_step;
  bit     captured;
  longint yaw_tgt, pitch_tgt, yaw_int, pitch_int, prev_yaw, prev_pitch;
  longint prev_ex, prev_ey, sw_tgt;
  logic [1:0] sw_dir;

  function automatic longint qconst(longint n, longint d);
    return ((n <<< FB) + d / 2) / d;
  endfunction

  function automatic longint floor_q(longint v);
    return v >= 0 ? v / ONE : -((-v + ONE - 1) / ONE);
  endfunction

  function automatic longint axis_pid(longint err, ref longint integ, input longint igain,
                                      longint pgain, longint ogain, longint drate,
                                      longint dgain);
    longint o;
    integ += floor_q(err * igain);
    if (integ > gtpc_pkg::INTEG_LIMIT * ONE) integ = gtpc_pkg::INTEG_LIMIT * ONE;
    if (integ < -gtpc_pkg::INTEG_LIMIT * ONE) integ = -gtpc_pkg::INTEG_LIMIT * ONE;
    if (err > gtpc_pkg::ERROR_LIMIT * ONE || err < -gtpc_pkg::ERROR_LIMIT * ONE) integ = 0;
    o = err * pgain + floor_q(integ * ogain) - drate * dgain;
    if (o > gtpc_pkg::DRIVE_LIMIT * ONE) o = gtpc_pkg::DRIVE_LIMIT * ONE;
    if (o < -gtpc_pkg::DRIVE_LIMIT * ONE) o = -gtpc_pkg::DRIVE_LIMIT * ONE;
    return o / ONE;
  endfunction

  task automatic predict_tick();
    longint tx, ty, tw, gy, gp, sy, sp, pos, spin, aim, yerr, perr, yrate, yd, pd;
    longint ex, ey, p, ax, ay;
    drive_t r;
    tx = in_if.target_x; ty = in_if.target_y; tw = in_if.target_width;
    gy = in_if.gyro_yaw; gp = in_if.gyro_pitch;
    sy = in_if.stick_yaw; sp = in_if.stick_pitch;
    pos = in_if.pitch_position; spin = in_if.spin_rate;
    aim = ctr_y + (tw <= 6 ? 5 : 0);
    if (in_if.mode) captured = in_if.loss_count < 3;
    if (in_if.switch_pos == 2'd0) begin
      drive_q.push_back('0);
      return;
    end
    if (in_if.mode && captured) begin
      if (tx != 0 || ty != 0) begin
        ex = tx - ctr_x;
        ey = ty - aim;
        p = (ex * qconst(95, 100)) / ONE;
        if (p > gtpc_pkg::P_CLAMP) p = gtpc_pkg::P_CLAMP;
        if (p < -gtpc_pkg::P_CLAMP) p = -gtpc_pkg::P_CLAMP;
        ax = (p * ONE + (ex - prev_ex) * qconst(6, 10)) / ONE;
        ay = (ey * qconst(72, 100) + (ey - prev_ey) * qconst(9, 10)) / ONE;
        prev_ex = ex;
        prev_ey = ey;
        yaw_tgt = -10 * ax * ONE;
        pitch_tgt = -10 * ay * ONE;
      end
      if (in_if.loss_count == 8'd1) begin
        yaw_tgt = 0;
        pitch_tgt = 0;
      end
      yerr = yaw_tgt - gy * ONE + qconst(76207, 10000);
      perr = pitch_tgt - gp * ONE - qconst(3321, 1000);
      yd = axis_pid(yerr, yaw_int, qconst(188, 100), 17, qconst(12, 100),
                    gy - prev_yaw, qconst(25, 10));
      pd = axis_pid(perr, pitch_int, qconst(118, 100), 16, qconst(32, 100),
                    gp - prev_pitch, 2 * ONE);
      prev_yaw = gy;
    end else if (in_if.mode) begin
      if (pos >= sw_hi) sw_dir = gtpc_pkg::DIR_DOWN;
      else if (pos <= sw_lo) sw_dir = gtpc_pkg::DIR_UP;
      if (sw_dir == gtpc_pkg::DIR_UP) sw_tgt = sw_step;
      if (sw_dir == gtpc_pkg::DIR_DOWN) sw_tgt = -sw_step;
      if (sw_test == 0) begin
        yaw_tgt = -8 * ONE + (880 * spin * ONE) / 256;
        pitch_tgt = 0;
      end else begin
        yaw_tgt = 0;
        pitch_tgt = sw_tgt * ONE;
      end
      yerr = yaw_tgt - gy * ONE + qconst(76207, 10000);
      perr = pitch_tgt - gp * ONE - qconst(3321, 1000);
      yd = axis_pid(yerr, yaw_int, qconst(188, 100), 16, ONE, gy - prev_yaw, qconst(15, 10));
      pd = axis_pid(perr, pitch_int, qconst(118, 100), 16, ONE, gp - prev_pitch, ONE);
      prev_yaw = gy;
    end else begin
      yrate = gy + yaw_ofs;
      yaw_tgt = -(sy - 1024) * 8 * ONE;
      pitch_tgt = (sp - 1024) * 8 * ONE;
      yerr = yaw_tgt - yrate * ONE + qconst(76207, 10000);
      perr = pitch_tgt - gp * ONE - qconst(3321, 1000);
      yd = axis_pid(yerr, yaw_int, qconst(118, 100), 18, ONE,
                    yrate - prev_yaw, qconst(12, 10));
      pd = axis_pid(perr, pitch_int, qconst(118, 100), 18, ONE,
                    gp - prev_pitch, qconst(2, 10));
      prev_yaw = yrate;
    end
    prev_pitch = gp;
    r.yaw_drive = yd[15:0];
    r.pitch_drive = pd[15:0];
    r.drive_enabled = 1'b1;
    drive_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    drive_t e;
    if (!rst_n) begin
      ctr_x = 560; ctr_y = 440; yaw_ofs = 9; sw_test = 0;
      sw_lo = 3700; sw_hi = 4500; sw_step = 300;
      captured = 0; yaw_tgt = 0; pitch_tgt = 0; yaw_int = 0; pitch_int = 0;
      prev_yaw = 0; prev_pitch = 0; prev_ex = 0; prev_ey = 0;
      sw_dir = gtpc_pkg::DIR_NONE; sw_tgt = 400;
      drive_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          gtpc_pkg::REG_CENTER_X:  ctr_x = pwdata[9:0];
          gtpc_pkg::REG_CENTER_Y:  ctr_y = pwdata[9:0];
          gtpc_pkg::REG_YAW_OFS:   yaw_ofs = pwdata[7:0];
          gtpc_pkg::REG_SWEEP_TST: sw_test = pwdata[0];
          gtpc_pkg::REG_SWEEP_LO:  sw_lo = pwdata[12:0];
          gtpc_pkg::REG_SWEEP_HI:  sw_hi = pwdata[12:0];
          gtpc_pkg::REG_SWEEP_STP: sw_step = pwdata[11:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (drive_q.size() == 0) begin
          $display("unexpected drive item");
          fail_count++;
        end else begin
          e = drive_q.pop_front();
          if (out_if.yaw_drive !== e.yaw_drive)
            report_mismatch("yaw_drive", out_if.yaw_drive, e.yaw_drive);
          if (out_if.pitch_drive !== e.pitch_drive)
            report_mismatch("pitch_drive", out_if.pitch_drive, e.pitch_drive);
          if (out_if.drive_enabled !== e.drive_enabled)
            report_mismatch("drive_enabled", out_if.drive_enabled, e.drive_enabled);
        end
      end
      if (in_if.valid && in_if.ready) predict_tick();
    end
    pending_count = drive_q.size();
  end
endmodule

// ===== tb/sv/tb_gimbal_two_axis_pid_controller_core.sv =====
// Testbench top for the gimbal controller core: stimulus, register setup and verdict
`timescale 1ns / 100ps
module tb_gimbal_two_axis_pid_controller_core;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit hold_recv = 0;
  bit sweep_bias = 0;

  gtpc_in_if  in_if ();
  gtpc_out_if out_if ();

  gimbal_two_axis_pid_controller_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tb_gimbal_two_axis_pid_controller_core_chk chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .fail_count(fail_count), .pending_count(pending_count)
  );

  always #4 clk = ~clk;

  initial begin
    in_if.valid = 1'b0; in_if.mode = 1'b0; in_if.switch_pos = '0;
    in_if.loss_count = '0; in_if.target_x = '0; in_if.target_y = '0;
    in_if.target_width = '0; in_if.gyro_yaw = '0; in_if.gyro_pitch = '0;
    in_if.stick_yaw = 11'd1024; in_if.stick_pitch = 11'd1024;
    in_if.pitch_position = '0; in_if.spin_rate = '0;
    out_if.ready = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_recv) begin
        out_if.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_recv = 0;
      end
      g = pick_gap();
      if (g > 0) begin
        out_if.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drop valid after the last item, then wait for every result
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Present one tick and hold it until accepted; keep valid high if back to back
  task automatic send_tick(logic md, logic [1:0] sw, logic [7:0] loss, logic [9:0] tx,
                           logic [9:0] ty, logic [9:0] tw, logic [15:0] gy,
                           logic [15:0] gp, logic [10:0] sy, logic [10:0] sp,
                           logic [12:0] pos, logic [11:0] spin);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= md; in_if.switch_pos <= sw; in_if.loss_count <= loss;
    in_if.target_x <= tx; in_if.target_y <= ty; in_if.target_width <= tw;
    in_if.gyro_yaw <= gy; in_if.gyro_pitch <= gp;
    in_if.stick_yaw <= sy; in_if.stick_pitch <= sp;
    in_if.pitch_position <= pos; in_if.spin_rate <= spin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_gyro();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 80)) - 40);
      1: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic rand_tick();
    logic md;
    logic [1:0] sw;
    logic [7:0] loss;
    logic [9:0] tx, ty;
    logic [11:0] spin;
    md = $urandom_range(0, 2) != 0;
    sw = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    case ($urandom_range(0, 5))
      0: loss = 8'($urandom);
      1, 2: loss = 8'($urandom_range(3, 6));
      default: loss = 8'($urandom_range(0, 2));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      tx = '0; ty = '0;
    end else begin
      tx = 10'($urandom); ty = 10'($urandom);
    end
    spin = 12'($signed($urandom_range(0, 2048)) - 1024);
    if ($urandom_range(0, 15) == 0) spin = 12'($urandom);
    send_tick(md, sw, loss, tx, ty, 10'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 9)),
              rand_gyro(), rand_gyro(), 11'($urandom), 11'($urandom),
              sweep_bias ? 13'($urandom_range(3000, 5200)) : 13'($urandom), spin);
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: manual extremes, disabled switch, tracking, loss one, search paths
    send_tick(1'b0, 2'd1, 8'd0, '0, '0, '0, 16'sd0, 16'sd0, 11'd1024, 11'd1024, '0, '0);
    send_tick(1'b0, 2'd3, 8'd0, '0, '0, '0, 16'h7FFF, 16'h8000, 11'd0, 11'd2047, '0, '0);
    send_tick(1'b0, 2'd2, 8'd0, '0, '0, '0, 16'h8000, 16'h7FFF, 11'd2047, 11'd0, '0, '0);
    send_tick(1'b0, 2'd0, 8'd0, '0, '0, '0, 16'h1234, 16'h4321, 11'd0, 11'd0, '0, '0);
    send_tick(1'b1, 2'd0, 8'd0, 10'd1023, 10'd1023, '0, '0, '0, 11'd1024, 11'd1024, '0, '0);
    send_tick(1'b1, 2'd1, 8'd0, 10'd1023, 10'd1023, 10'd1023, 16'sd5, -16'sd5,
              11'd1024, 11'd1024, '0, '0);
    send_tick(1'b1, 2'd1, 8'd2, 10'd1, 10'd0, 10'd6, '0, '0, 11'd1024, 11'd1024, '0, '0);
    send_tick(1'b1, 2'd1, 8'd0, 10'd0, 10'd0, 10'd7, '0, '0, 11'd1024, 11'd1024, '0, '0);
    send_tick(1'b1, 2'd1, 8'd1, 10'd600, 10'd400, 10'd3, '0, '0, 11'd1024, 11'd1024, '0, '0);
    send_tick(1'b1, 2'd2, 8'd3, '0, '0, '0, '0, '0, 11'd1024, 11'd1024, 13'd4000, 12'h400);
    send_tick(1'b1, 2'd2, 8'd255, '0, '0, '0, '0, '0, 11'd1024, 11'd1024, 13'd8191, 12'hC00);
    send_tick(1'b1, 2'd3, 8'd9, '0, '0, '0, 16'h7FFF, 16'h8000, 11'd0, 11'd0, 13'd0, 12'hFFF);
    wait_drained();
    reg_write(gtpc_pkg::REG_SWEEP_TST, 32'd1);
    reg_write(gtpc_pkg::REG_SWEEP_STP, 32'd4095);
    reg_write(gtpc_pkg::REG_YAW_OFS, 32'd255);
    reg_write(gtpc_pkg::REG_CENTER_X, 32'd0);
    reg_write(gtpc_pkg::REG_CENTER_Y, 32'd1023);
    send_tick(1'b1, 2'd1, 8'd5, '0, '0, '0, '0, '0, 11'd1024, 11'd1024, 13'd4000, '0);
    send_tick(1'b1, 2'd1, 8'd5, '0, '0, '0, '0, '0, 11'd1024, 11'd1024, 13'd0, '0);
    send_tick(1'b1, 2'd1, 8'd5, '0, '0, '0, '0, '0, 11'd1024, 11'd1024, 13'd8191, '0);
    send_tick(1'b1, 2'd1, 8'd0, 10'd1023, 10'd0, 10'd0, '0, '0, 11'd1024, 11'd1024, '0, '0);
    send_tick(1'b0, 2'd1, 8'd0, '0, '0, '0, 16'h8000, '0, 11'd5, 11'd2000, '0, '0);
    wait_drained();
    // Crossed sweep limits
    reg_write(gtpc_pkg::REG_SWEEP_LO, 32'd5000);
    reg_write(gtpc_pkg::REG_SWEEP_HI, 32'd3000);
    send_tick(1'b1, 2'd1, 8'd4, '0, '0, '0, '0, '0, 11'd1024, 11'd1024, 13'd4000, '0);
    send_tick(1'b1, 2'd1, 8'd4, '0, '0, '0, '0, '0, 11'd1024, 11'd1024, 13'd2000, '0);
    wait_drained();
    // Random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(gtpc_pkg::REG_SWEEP_LO, 32'd3700);
          reg_write(gtpc_pkg::REG_SWEEP_HI, 32'd4500);
          reg_write(gtpc_pkg::REG_CENTER_X, 32'd560);
          reg_write(gtpc_pkg::REG_CENTER_Y, 32'd440);
          reg_write(gtpc_pkg::REG_SWEEP_STP, 32'd300);
          reg_write(gtpc_pkg::REG_SWEEP_TST, 32'd0);
        end
        1: begin
          reg_write(gtpc_pkg::REG_SWEEP_TST, 32'd1);
          reg_write(gtpc_pkg::REG_YAW_OFS, 32'd0);
          reg_write(gtpc_pkg::REG_SWEEP_STP, 32'd0);
        end
        2: begin
          reg_write(gtpc_pkg::REG_CENTER_X, 32'd1023);
          reg_write(gtpc_pkg::REG_CENTER_Y, 32'd0);
          reg_write(gtpc_pkg::REG_SWEEP_LO, 32'd0);
          reg_write(gtpc_pkg::REG_SWEEP_HI, 32'd8191);
          reg_write(gtpc_pkg::REG_SWEEP_STP, 32'd4095);
        end
        default: begin
          reg_write(gtpc_pkg::REG_CENTER_X, $urandom_range(0, 1023));
          reg_write(gtpc_pkg::REG_CENTER_Y, $urandom_range(0, 1023));
          reg_write(gtpc_pkg::REG_YAW_OFS, $urandom_range(0, 255));
          reg_write(gtpc_pkg::REG_SWEEP_TST, $urandom_range(0, 1));
          reg_write(gtpc_pkg::REG_SWEEP_LO, $urandom_range(3000, 4200));
          reg_write(gtpc_pkg::REG_SWEEP_HI, $urandom_range(3800, 5000));
          reg_write(gtpc_pkg::REG_SWEEP_STP, $urandom_range(0, 4095));
        end
      endcase
      sweep_bias = ph >= 3;
      if (ph == 1) hold_recv = 1;
      n = 0;
      while (n < 305) begin
        rand_tick();
        n++;
      end
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
